// File: rtl/core/pctd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pctd_pkg;

  // Charset selection held in the configuration register
  localparam logic CHARSET_UTF8   = 1'b0;
  localparam logic CHARSET_LATIN1 = 1'b1;

  // Token queue between the escape decoder and the UTF-8 stage
  localparam int unsigned TOKQ_DEPTH = 4;
  localparam int unsigned TOKQ_AW    = $clog2(TOKQ_DEPTH);

  // One raw input request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_value;
  } in_item_t;

  // One UTF-8 output byte
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // One decoded byte, or an end-only marker when has_byte is low
  typedef struct packed {
    logic [7:0] tok_byte;
    logic       has_byte;
    logic       fin;
  } tok_t;

endpackage

`default_nettype wire

// File: rtl/core/pctd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pctd_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire pctd_pkg::in_item_t in_data,
  output logic                    tok_valid,
  input  wire logic               tok_ready,
  output pctd_pkg::tok_t          tok_data
);

  localparam logic [7:0] CHAR_PCT = 8'h25;

  typedef enum logic [1:0] {
    PCT_IDLE,
    PCT_SEEN,
    PCT_HEX
  } pct_state_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  // digits map straight from the low nibble, letters add nine
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    return (c <= 8'h39) ? c[3:0] : 4'(c[3:0] + 4'd9);
  endfunction

  pct_state_t pct_st_r, st_nxt;
  logic [7:0] pct_hex_r, hex_nxt;
  logic [7:0] buf_r [0:2];
  logic [1:0] buf_n_r;
  logic [1:0] buf_idx_r;
  logic       buf_fin_r;
  logic       buf_busy_r;

  logic [7:0] dec_lst [0:2];
  logic [1:0] dec_n;
  logic       tail;
  logic       accept;
  logic       tok_take;
  logic       tok_last;

  // token presented from the buffer, one per cycle while tok_ready is high
  assign tok_last  = (buf_n_r == 2'd0) || (buf_idx_r == 2'(buf_n_r - 2'd1));
  assign tok_valid = buf_busy_r;
  assign tok_take  = tok_valid && tok_ready;
  assign tok_data.tok_byte = buf_r[buf_idx_r];
  assign tok_data.has_byte = (buf_n_r != 2'd0);
  assign tok_data.fin      = buf_fin_r && tok_last;

  assign in_stall = buf_busy_r && !(tok_take && tok_last);
  assign accept   = in_valid && !in_stall;

  // escape decode: list of up to three bytes released by this request
  always_comb begin
    dec_lst[0] = 8'h00;
    dec_lst[1] = 8'h00;
    dec_lst[2] = 8'h00;
    dec_n      = 2'd0;
    st_nxt     = pct_st_r;
    hex_nxt    = pct_hex_r;
    tail       = 1'b0;
    if (in_data.byte_valid) begin
      case (pct_st_r)
        PCT_SEEN: begin
          if (is_hex(in_data.data_byte)) begin
            hex_nxt = in_data.data_byte;
            st_nxt  = PCT_HEX;
          end else begin
            dec_lst[0] = CHAR_PCT;
            dec_n      = 2'd1;
            tail       = 1'b1;
          end
        end
        PCT_HEX: begin
          // the held digit is always hex, only the new one needs checking
          if (is_hex(in_data.data_byte)) begin
            dec_lst[0] = {hex_val(pct_hex_r), hex_val(in_data.data_byte)};
            dec_n      = 2'd1;
            st_nxt     = PCT_IDLE;
          end else begin
            dec_lst[0] = CHAR_PCT;
            dec_lst[1] = pct_hex_r;
            dec_n      = 2'd2;
            tail       = 1'b1;
          end
        end
        default: tail = 1'b1;
      endcase
      if (tail) begin
        if (in_data.data_byte == CHAR_PCT) begin
          st_nxt = PCT_SEEN;
        end else begin
          st_nxt         = PCT_IDLE;
          dec_lst[dec_n] = in_data.data_byte;
          dec_n          = dec_n + 2'd1;
        end
      end
    end
    // end of value: an open escape goes out literally
    if (in_data.end_of_value) begin
      if (st_nxt != PCT_IDLE) begin
        dec_lst[dec_n] = CHAR_PCT;
        dec_n          = dec_n + 2'd1;
      end
      if (st_nxt == PCT_HEX) begin
        dec_lst[dec_n] = hex_nxt;
        dec_n          = dec_n + 2'd1;
      end
      st_nxt = PCT_IDLE;
    end
  end

  // escape state and token buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_st_r   <= PCT_IDLE;
      buf_busy_r <= 1'b0;
      buf_idx_r  <= 2'd0;
      buf_n_r    <= 2'd0;
      buf_fin_r  <= 1'b0;
    end else if (accept) begin
      pct_st_r  <= st_nxt;
      pct_hex_r <= hex_nxt;
      if (dec_n != 2'd0 || in_data.end_of_value) begin
        buf_busy_r <= 1'b1;
        buf_r      <= dec_lst;
        buf_n_r    <= dec_n;
        buf_fin_r  <= in_data.end_of_value;
        buf_idx_r  <= 2'd0;
      end else begin
        buf_busy_r <= 1'b0;
      end
    end else if (tok_take) begin
      if (tok_last) begin
        buf_busy_r <= 1'b0;
      end else begin
        buf_idx_r <= buf_idx_r + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/pctd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module pctd_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire pctd_pkg::tok_t push_data,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output pctd_pkg::tok_t      pop_data
);

  localparam int unsigned AW = pctd_pkg::TOKQ_AW;

  pctd_pkg::tok_t mem_r [0:pctd_pkg::TOKQ_DEPTH-1];
  logic [AW-1:0]  wr_ptr_r;
  logic [AW-1:0]  rd_ptr_r;
  logic [AW:0]    cnt_r;
  logic           push;
  logic           pop;

  assign push_ready = (cnt_r != (AW+1)'(pctd_pkg::TOKQ_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + AW'(1);
      if (push && !pop) begin
        cnt_r <= cnt_r + (AW+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (AW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/pctd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pctd_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           charset_mode,
  input  wire logic           tok_valid,
  output logic                tok_ready,
  input  wire pctd_pkg::tok_t tok_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output pctd_pkg::out_item_t out_data
);

  localparam logic [7:0] REPL_0 = 8'hEF;
  localparam logic [7:0] REPL_1 = 8'hBF;
  localparam logic [7:0] REPL_2 = 8'hBD;

  // window of held sequence bytes plus the incoming one
  logic [7:0] win_r [0:3];
  logic [2:0] win_n_r;
  logic       tok_busy_r;
  logic       tok_fin_r;

  // emission list and output register
  logic [7:0] em_r [0:3];
  logic [2:0] em_n_r;
  logic [1:0] em_idx_r;
  logic       em_last_r;
  logic       em_busy_r;
  logic       out_valid_r;
  pctd_pkg::out_item_t out_data_r;

  logic       out_can, em_push, em_final, dec_en, pop, latin_pop, eff_fin;
  logic [7:0] ew [0:3];
  logic [2:0] en;
  logic [7:0] b0;
  logic       is_ascii, lead_ok, cont_ok, incomplete;
  logic [1:0] need;
  logic       cf1, cf2, cf3;
  logic [20:0] cp;
  logic [7:0] cp_lst [0:3];
  logic [2:0] cp_n;

  logic       ld_em, ld_last;
  logic [7:0] ld_lst [0:3];
  logic [2:0] ld_n;
  logic [2:0] shift;
  logic [7:0] win_nxt [0:3];
  logic [2:0] win_n_nxt;
  logic       busy_nxt, fin_nxt;

  assign out_can  = !out_valid_r || !out_stall;
  assign em_push  = em_busy_r && out_can;
  assign em_final = ({1'b0, em_idx_r} == 3'(em_n_r - 3'd1));
  assign dec_en   = !em_busy_r || (em_push && em_final);
  assign tok_ready = dec_en && !tok_busy_r;
  assign pop       = tok_ready && tok_valid;
  assign latin_pop = pop && tok_data.has_byte && (charset_mode == pctd_pkg::CHARSET_LATIN1);
  assign eff_fin   = pop ? tok_data.fin : tok_fin_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // append the new byte to the window in UTF-8 mode
  always_comb begin
    ew = win_r;
    en = win_n_r;
    if (pop && tok_data.has_byte && (charset_mode == pctd_pkg::CHARSET_UTF8)) begin
      ew[win_n_r[1:0]] = tok_data.tok_byte;
      en               = win_n_r + 3'd1;
    end
  end

  // classify the lead byte and its continuation candidates
  assign b0       = ew[0];
  assign is_ascii = !b0[7];
  assign cf1      = (ew[1][7:6] == 2'b10);
  assign cf2      = (ew[2][7:6] == 2'b10);
  assign cf3      = (ew[3][7:6] == 2'b10);

  always_comb begin
    if (b0[7:5] == 3'b110) begin
      need = 2'd1; lead_ok = 1'b1;
    end else if (b0[7:4] == 4'b1110) begin
      need = 2'd2; lead_ok = 1'b1;
    end else if (b0[7:3] == 5'b11110) begin
      need = 2'd3; lead_ok = 1'b1;
    end else begin
      need = 2'd0; lead_ok = 1'b0;
    end
  end

  assign incomplete = lead_ok && ({1'b0, need} >= en);

  // code point assembly and shortest-form encoding
  always_comb begin
    case (need)
      2'd1: begin
        cont_ok = cf1;
        cp      = {10'd0, b0[4:0], ew[1][5:0]};
      end
      2'd2: begin
        cont_ok = cf1 && cf2;
        cp      = {5'd0, b0[3:0], ew[1][5:0], ew[2][5:0]};
      end
      2'd3: begin
        cont_ok = cf1 && cf2 && cf3;
        cp      = {b0[2:0], ew[1][5:0], ew[2][5:0], ew[3][5:0]};
      end
      default: begin
        cont_ok = 1'b0;
        cp      = 21'd0;
      end
    endcase
  end

  always_comb begin
    cp_lst[0] = 8'h00;
    cp_lst[1] = 8'h00;
    cp_lst[2] = 8'h00;
    cp_lst[3] = 8'h00;
    if (cp[20:7] == 14'd0) begin
      cp_lst[0] = {1'b0, cp[6:0]};
      cp_n      = 3'd1;
    end else if (cp[20:11] == 10'd0) begin
      cp_lst[0] = {3'b110, cp[10:6]};
      cp_lst[1] = {2'b10, cp[5:0]};
      cp_n      = 3'd2;
    end else if (cp[20:16] == 5'd0) begin
      cp_lst[0] = {4'b1110, cp[15:12]};
      cp_lst[1] = {2'b10, cp[11:6]};
      cp_lst[2] = {2'b10, cp[5:0]};
      cp_n      = 3'd3;
    end else begin
      cp_lst[0] = {5'b11110, cp[20:18]};
      cp_lst[1] = {2'b10, cp[17:12]};
      cp_lst[2] = {2'b10, cp[11:6]};
      cp_lst[3] = {2'b10, cp[5:0]};
      cp_n      = 3'd4;
    end
  end

  // one decision per free emission slot
  always_comb begin
    ld_em     = 1'b0;
    ld_last   = 1'b0;
    ld_lst[0] = 8'h00;
    ld_lst[1] = 8'h00;
    ld_lst[2] = 8'h00;
    ld_lst[3] = 8'h00;
    ld_n      = 3'd0;
    shift     = 3'd0;
    win_nxt   = win_r;
    win_n_nxt = win_n_r;
    busy_nxt  = tok_busy_r;
    fin_nxt   = tok_fin_r;
    if (dec_en && (tok_busy_r || pop)) begin
      if (latin_pop) begin
        ld_em = 1'b1;
        if (tok_data.tok_byte[7]) begin
          ld_lst[0] = {6'b110000, tok_data.tok_byte[7:6]};
          ld_lst[1] = {2'b10, tok_data.tok_byte[5:0]};
          ld_n      = 3'd2;
        end else begin
          ld_lst[0] = tok_data.tok_byte;
          ld_n      = 3'd1;
        end
        // bytes held from UTF-8 mode still need their flush
        if (tok_data.fin && win_n_r != 3'd0) begin
          busy_nxt = 1'b1;
          fin_nxt  = 1'b1;
        end else begin
          busy_nxt = 1'b0;
          ld_last  = tok_data.fin;
        end
      end else begin
        busy_nxt = 1'b0;
        if (en != 3'd0) begin
          if (is_ascii) begin
            ld_lst[0] = b0;
            ld_n      = 3'd1;
            shift     = 3'd1;
          end else if (!lead_ok || (!incomplete && !cont_ok)) begin
            ld_lst[0] = REPL_0;
            ld_lst[1] = REPL_1;
            ld_lst[2] = REPL_2;
            ld_n      = 3'd3;
            shift     = 3'd1;
          end else if (incomplete) begin
            if (eff_fin) begin
              // truncated sequence: one replacement, held bytes dropped
              ld_em     = 1'b1;
              ld_last   = 1'b1;
              ld_lst[0] = REPL_0;
              ld_lst[1] = REPL_1;
              ld_lst[2] = REPL_2;
              ld_n      = 3'd3;
              win_n_nxt = 3'd0;
            end else begin
              win_nxt   = ew;
              win_n_nxt = en;
            end
          end else begin
            ld_lst = cp_lst;
            ld_n   = cp_n;
            shift  = {1'b0, need} + 3'd1;
          end
          if (shift != 3'd0) begin
            ld_em     = 1'b1;
            win_n_nxt = en - shift;
            case (shift)
              3'd1: win_nxt = '{ew[1], ew[2], ew[3], 8'h00};
              3'd2: win_nxt = '{ew[2], ew[3], 8'h00, 8'h00};
              3'd3: win_nxt = '{ew[3], 8'h00, 8'h00, 8'h00};
              default: win_nxt = '{8'h00, 8'h00, 8'h00, 8'h00};
            endcase
            if (en == shift) begin
              ld_last = eff_fin;
            end else begin
              busy_nxt = 1'b1;
              fin_nxt  = eff_fin;
            end
          end
        end
      end
    end
  end

  // window, emission list and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_n_r     <= 3'd0;
      tok_busy_r  <= 1'b0;
      tok_fin_r   <= 1'b0;
      em_busy_r   <= 1'b0;
      em_n_r      <= 3'd0;
      em_idx_r    <= 2'd0;
      em_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      win_r      <= win_nxt;
      win_n_r    <= win_n_nxt;
      tok_busy_r <= busy_nxt;
      tok_fin_r  <= fin_nxt;
      if (ld_em) begin
        em_r      <= ld_lst;
        em_n_r    <= ld_n;
        em_idx_r  <= 2'd0;
        em_last_r <= ld_last;
        em_busy_r <= 1'b1;
      end else if (em_push) begin
        if (em_final) begin
          em_busy_r <= 1'b0;
        end else begin
          em_idx_r <= em_idx_r + 2'd1;
        end
      end
      if (em_push) begin
        out_valid_r         <= 1'b1;
        out_data_r.out_byte <= em_r[em_idx_r];
        out_data_r.out_last <= em_last_r && em_final;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/percent_decode_charset_to_utf8.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake        Payload
// in_      input      in_valid/stall   pctd_pkg::in_item_t  (one raw byte / end mark)
// out_     output     out_valid/stall  pctd_pkg::out_item_t (one UTF-8 byte, last flag)
// cfg_     input      cfg_valid/ready  charset_mode (1 bit), ready always high
//
// The escape decoder takes one request per cycle while in_stall is low and
// releases 0 to 3 decoded bytes, one per cycle as the queue takes them, into
// a four-entry token queue; it stalls the next request until the last of them
// is taken. The UTF-8 stage writes one output byte per cycle while out_stall
// is low, up to 18 per request; a token that leaves a partial sequence held gives no output.
// Synchronous reset clears all control state.
// Either side may stall without stopping the other until the queue fills.

module percent_decode_charset_to_utf8 (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire pctd_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output pctd_pkg::out_item_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_data
);

  logic           charset_mode_r;
  logic           fq_valid, fq_ready;
  pctd_pkg::tok_t fq_data;
  logic           qb_valid, qb_ready;
  pctd_pkg::tok_t qb_data;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      charset_mode_r <= pctd_pkg::CHARSET_UTF8;
    end else if (cfg_valid && cfg_ready) begin
      charset_mode_r <= cfg_data;
    end
  end

  // escape decoder
  pctd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .tok_valid (fq_valid),
    .tok_ready (fq_ready),
    .tok_data  (fq_data)
  );

  // decoupling queue
  pctd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  // UTF-8 repair / Latin-1 conversion
  pctd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .charset_mode (charset_mode_r),
    .tok_valid    (qb_valid),
    .tok_ready    (qb_ready),
    .tok_data     (qb_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule

`default_nettype wire

// File: tb/pctd_stream_checker.sv
`timescale 1ns / 1ps

module pctd_stream_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  pctd_pkg::in_item_t            in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  pctd_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic                          cfg_data,
  output int                            err_count,
  output int                            pending
);

  localparam int         MAX_SHOWN = 10;
  localparam int         STEP_MAX  = 18;
  localparam int         EXP_DEPTH = 512;
  localparam logic [7:0] PCT_CHAR  = 8'h25;

  // Mirror of the decoder state
  logic       charset_mode;
  logic [7:0] esc_digit;
  logic [1:0] esc_cnt;
  logic [7:0] seq_held [3];
  logic [1:0] seq_cnt;

  // Results of one request, then the expected stream in arrival order
  pctd_pkg::out_item_t step_buf [STEP_MAX];
  int                  step_n;
  pctd_pkg::out_item_t exp_mem [EXP_DEPTH];
  int                  exp_wr;
  int                  exp_rd;
  pctd_pkg::out_item_t want;
  int                  result_no;

  function automatic int hex_nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic void emit_byte(input logic [7:0] b);
    pctd_pkg::out_item_t r;
    r.out_byte = b;
    r.out_last = 1'b0;
    if (step_n < STEP_MAX) begin
      step_buf[step_n] = r;
      step_n++;
    end
  endfunction

  function automatic void emit_replacement();
    emit_byte(8'hEF);
    emit_byte(8'hBF);
    emit_byte(8'hBD);
  endfunction

  // Shortest-form encoding of a code point
  function automatic void emit_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      emit_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      emit_byte({3'b110, cp[10:6]});
      emit_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      emit_byte({4'b1110, cp[15:12]});
      emit_byte({2'b10, cp[11:6]});
      emit_byte({2'b10, cp[5:0]});
    end else begin
      emit_byte({5'b11110, cp[20:18]});
      emit_byte({2'b10, cp[17:12]});
      emit_byte({2'b10, cp[11:6]});
      emit_byte({2'b10, cp[5:0]});
    end
  endfunction

  // UTF-8 repair: held bytes plus the new one are rescanned from the start
  function automatic void repair_feed(input logic [7:0] b);
    logic [7:0]  seq [4];
    logic [7:0]  lead;
    logic [7:0]  c;
    logic [20:0] cp;
    int          len;
    int          i;
    int          k;
    int          need;
    bit          ok;
    len = 0;
    for (k = 0; k < seq_cnt; k++) begin
      seq[len] = seq_held[k];
      len++;
    end
    seq[len] = b;
    len++;
    seq_cnt = 0;
    i = 0;
    while (i < len) begin
      lead = seq[i];
      need = 0;
      cp   = '0;
      if (lead < 8'h80) begin
        emit_byte(lead);
        i++;
        continue;
      end
      if ((lead & 8'hE0) == 8'hC0) begin
        need = 1;
        cp   = 21'(lead & 8'h1F);
      end else if ((lead & 8'hF0) == 8'hE0) begin
        need = 2;
        cp   = 21'(lead & 8'h0F);
      end else if ((lead & 8'hF8) == 8'hF0) begin
        need = 3;
        cp   = 21'(lead & 8'h07);
      end
      if (need == 0) begin
        emit_replacement();
        i++;
        continue;
      end
      // incomplete: hold the lead and whatever follows it
      if (i + need >= len) begin
        for (k = i; k < len; k++) begin
          seq_held[seq_cnt] = seq[k];
          seq_cnt++;
        end
        return;
      end
      ok = 1'b1;
      for (k = 1; k <= need; k++) begin
        c = seq[i + k];
        if ((c & 8'hC0) != 8'h80) ok = 1'b0;
        cp = {cp[14:0], c[5:0]};
      end
      if (!ok) begin
        emit_replacement();
        i++;
      end else begin
        emit_code_point(cp);
        i += need + 1;
      end
    end
  endfunction

  function automatic void decoded_out(input logic [7:0] b);
    if (charset_mode == pctd_pkg::CHARSET_LATIN1) begin
      if (b < 8'h80) begin
        emit_byte(b);
      end else begin
        emit_byte({6'b110000, b[7:6]});
        emit_byte({2'b10, b[5:0]});
      end
    end else begin
      repair_feed(b);
    end
  endfunction

  // Escape decoder: '%' plus two hex digits becomes one byte
  function automatic void escape_feed(input logic [7:0] b);
    int         hi;
    int         lo;
    logic [7:0] val;
    if (esc_cnt == 2'd1) begin
      if (hex_nibble_of(b) >= 0) begin
        esc_digit = b;
        esc_cnt   = 2'd2;
        return;
      end
      esc_cnt = 2'd0;
      decoded_out(PCT_CHAR);
    end else if (esc_cnt == 2'd2) begin
      hi      = hex_nibble_of(esc_digit);
      lo      = hex_nibble_of(b);
      esc_cnt = 2'd0;
      if (hi >= 0 && lo >= 0) begin
        val = {hi[3:0], lo[3:0]};
        decoded_out(val);
        return;
      end
      decoded_out(PCT_CHAR);
      decoded_out(esc_digit);
    end else begin
      esc_cnt = 2'd0;
    end
    if (b == PCT_CHAR) esc_cnt = 2'd1;
    else decoded_out(b);
  endfunction

  // Expected output bytes for one accepted request
  function automatic void predict_request(input pctd_pkg::in_item_t req);
    logic [1:0] n;
    int         k;
    step_n = 0;
    if (req.byte_valid) escape_feed(req.data_byte);
    if (req.end_of_value) begin
      n       = esc_cnt;
      esc_cnt = 2'd0;
      if (n >= 2'd1) decoded_out(PCT_CHAR);
      if (n >= 2'd2) decoded_out(esc_digit);
      if (seq_cnt != 0) emit_replacement();
      esc_digit = '0;
      seq_held  = '{default: '0};
      seq_cnt   = '0;
      if (step_n > 0) step_buf[step_n - 1].out_last = 1'b1;
    end
    for (k = 0; k < step_n; k++) begin
      exp_mem[exp_wr % EXP_DEPTH] = step_buf[k];
      exp_wr++;
    end
  endfunction

  // Watch the channels on each rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      charset_mode = pctd_pkg::CHARSET_UTF8;
      esc_digit    = '0;
      esc_cnt      = '0;
      seq_held     = '{default: '0};
      seq_cnt      = '0;
      step_n       = 0;
      exp_wr       = 0;
      exp_rd       = 0;
      err_count    = 0;
      result_no    = 0;
    end else begin
      if (cfg_valid && cfg_ready) charset_mode = cfg_data;
      if (in_valid && !in_stall) predict_request(in_data);
      if (out_valid && !out_stall) begin
        if (exp_rd == exp_wr) begin
          if (err_count < MAX_SHOWN)
            $display("result %0d: exp none, got byte %02h last %0b",
                     result_no, out_data.out_byte, out_data.out_last);
          err_count++;
        end else begin
          want = exp_mem[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (out_data.out_byte !== want.out_byte ||
              out_data.out_last !== want.out_last) begin
            if (err_count < MAX_SHOWN)
              $display("result %0d: byte exp %02h got %02h, last exp %0b got %0b",
                       result_no, want.out_byte, out_data.out_byte,
                       want.out_last, out_data.out_last);
            err_count++;
          end
        end
        result_no++;
      end
    end
    pending = exp_wr - exp_rd;
  end

endmodule

// File: tb/percent_decode_charset_to_utf8_tb.sv
`timescale 1ns / 1ps

module percent_decode_charset_to_utf8_tb;

  localparam int RESET_CYCLES   = 9;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int SETTLE_CYCLES  = 32;
  localparam int RAND_PER_PHASE = 18;
  localparam int NUM_PHASES     = 5;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  pctd_pkg::in_item_t  in_data   = '0;
  logic                out_stall = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_data  = 1'b0;
  logic                in_stall;
  logic                out_valid;
  pctd_pkg::out_item_t out_data;
  logic                cfg_ready;

  int err_count;
  int pending;
  int idle_pct  = 0;
  int stall_pct = 0;
  int cycles    = 0;
  int rand_sent;

  always #6 clk = ~clk;

  percent_decode_charset_to_utf8 u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  pctd_stream_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .err_count (err_count),
    .pending   (pending)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // One request, with random idle cycles ahead of it; entered and left at a falling edge
  task automatic send_req(input logic [7:0] b, input logic bv, input logic fin);
    pctd_pkg::in_item_t req;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    req.data_byte    = b;
    req.byte_valid   = bv;
    req.end_of_value = fin;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold the sender off until every expected byte is out, then settle
  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_charset(input logic mode);
    wait_drained(SETTLE_CYCLES);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return "0" + nib;
    return ($urandom_range(1) ? "A" : "a") + nib - 4'd10;
  endfunction

  // A random piece of a value: mostly well-formed escapes and UTF-8, some noise
  task automatic send_random_part();
    logic [7:0]  dec [4];
    logic [7:0]  raw [16];
    logic [7:0]  b;
    logic [31:0] r;
    logic [20:0] cp;
    int          dec_n;
    int          raw_n;
    int          kind;
    int          len;
    int          conts;
    int          k;
    bit          fin_here;
    dec_n    = 0;
    raw_n    = 0;
    fin_here = ($urandom_range(99) < 20);
    kind     = $urandom_range(99);
    if (kind < 25) begin
      b = 8'($urandom_range(127));
      dec[dec_n] = b;
      dec_n++;
    end else if (kind < 55) begin
      len = $urandom_range(4, 1);
      case (len)
        1: begin
          cp = 21'($urandom_range(32'h7F));
          dec[0] = cp[7:0];
          dec_n  = 1;
        end
        2: begin
          cp = 21'($urandom_range(32'h7FF, 32'h80));
          dec[0] = {3'b110, cp[10:6]};
          dec[1] = {2'b10, cp[5:0]};
          dec_n  = 2;
        end
        3: begin
          cp = 21'($urandom_range(32'hFFFF, 32'h800));
          dec[0] = {4'b1110, cp[15:12]};
          dec[1] = {2'b10, cp[11:6]};
          dec[2] = {2'b10, cp[5:0]};
          dec_n  = 3;
        end
        default: begin
          cp = 21'($urandom_range(32'h10FFFF, 32'h10000));
          dec[0] = {5'b11110, cp[20:18]};
          dec[1] = {2'b10, cp[17:12]};
          dec[2] = {2'b10, cp[11:6]};
          dec[3] = {2'b10, cp[5:0]};
          dec_n  = 4;
        end
      endcase
    end else if (kind < 70) begin
      // any lead with random payload: overlong, surrogate, above range, or cut short
      len = $urandom_range(3, 1);
      r   = $urandom;
      case (len)
        1:       dec[0] = {3'b110, r[4:0]};
        2:       dec[0] = {4'b1110, r[3:0]};
        default: dec[0] = {5'b11110, r[2:0]};
      endcase
      dec_n = 1;
      conts = len;
      if (kind >= 64) begin
        conts    = $urandom_range(len - 1, 0);
        fin_here = 1'b1;
      end
      for (k = 0; k < conts; k++) begin
        r = $urandom;
        dec[dec_n] = {2'b10, r[5:0]};
        dec_n++;
      end
    end else if (kind < 82) begin
      len = $urandom_range(3, 1);
      for (k = 0; k < len; k++) begin
        b = 8'($urandom_range(255));
        raw[raw_n] = b;
        raw_n++;
      end
    end else begin
      // broken escape
      raw[raw_n] = "%";
      raw_n++;
      r = $urandom;
      if (r[0]) begin
        raw[raw_n] = hex_char(r[7:4]);
        raw_n++;
      end
      if (r[1]) begin
        b = 8'($urandom_range(255));
        raw[raw_n] = b;
        raw_n++;
      end
    end
    // decoded bytes travel raw or escaped
    for (k = 0; k < dec_n; k++) begin
      if ($urandom_range(1)) begin
        raw[raw_n]     = "%";
        raw[raw_n + 1] = hex_char(dec[k][7:4]);
        raw[raw_n + 2] = hex_char(dec[k][3:0]);
        raw_n += 3;
      end else begin
        raw[raw_n] = dec[k];
        raw_n++;
      end
    end
    for (k = 0; k < raw_n; k++) begin
      send_req(raw[k], 1'b1, fin_here && (k == raw_n - 1));
      rand_sent++;
    end
    if ($urandom_range(99) < 5) begin
      b = 8'($urandom_range(255));
      send_req(b, 1'b0, 1'b1);
      rand_sent++;
    end
    if ($urandom_range(99) < 4) begin
      b = 8'($urandom_range(255));
      send_req(b, 1'b0, 1'b0);
    end
  endtask

  initial begin
    int   phase;
    bit   held_off;
    logic mode;
    held_off = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    write_charset(pctd_pkg::CHARSET_UTF8);

    // Directed requests in UTF-8 mode
    send_req("%", 1'b1, 1'b0);
    send_req("4", 1'b1, 1'b0);
    send_req("1", 1'b1, 1'b0);
    send_req("%", 1'b1, 1'b0);
    send_req("c", 1'b1, 1'b0);
    send_req("3", 1'b1, 1'b0);
    send_req(8'hA9, 1'b1, 1'b0);
    // '%' with a bad second digit goes out literally
    send_req("%", 1'b1, 1'b0);
    send_req("F", 1'b1, 1'b0);
    send_req("g", 1'b1, 1'b0);
    // overlong pair, then a bad lead
    send_req(8'hC1, 1'b1, 1'b0);
    send_req(8'h81, 1'b1, 1'b0);
    send_req(8'hFF, 1'b1, 1'b0);
    // bad continuation
    send_req(8'hE2, 1'b1, 1'b0);
    send_req(8'h41, 1'b1, 1'b0);
    send_req(8'h42, 1'b1, 1'b0);
    // truncated at end of value
    send_req(8'hF0, 1'b1, 1'b0);
    send_req(8'h90, 1'b1, 1'b1);
    // truncation wins over a held non-continuation
    send_req(8'hE2, 1'b1, 1'b0);
    send_req(8'h41, 1'b1, 1'b1);
    // open '%x' flushed at the end
    send_req("%", 1'b1, 1'b0);
    send_req("4", 1'b1, 1'b1);
    // end with nothing to flag, and a request with no byte and no end
    send_req(8'h00, 1'b0, 1'b1);
    send_req(8'hFF, 1'b0, 1'b0);
    // surrogate re-encoded as it is
    send_req(8'hED, 1'b1, 1'b0);
    send_req(8'hA0, 1'b1, 1'b0);
    send_req(8'h80, 1'b1, 1'b0);
    // lead left held across the first mode change
    send_req(8'hC3, 1'b1, 1'b0);

    // Random phases with differing idle, stall and charset
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      mode = phase[0] ? pctd_pkg::CHARSET_UTF8 : pctd_pkg::CHARSET_LATIN1;
      write_charset(mode);
      case (phase)
        1:       begin idle_pct = 86; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 86; end
        3:       begin idle_pct = 14; stall_pct = 14; end
        default: begin idle_pct = 0;  stall_pct = 0;  end
      endcase
      rand_sent = 0;
      while (rand_sent < RAND_PER_PHASE) begin
        send_random_part();
        if (phase == 1 && !held_off && rand_sent >= RAND_PER_PHASE / 2) begin
          wait_drained(0);
          held_off = 1'b1;
        end
      end
    end

    wait_drained(SETTLE_CYCLES);
    if (err_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/pctd_pkg.sv
rtl/core/pctd_front.sv
rtl/core/pctd_fifo.sv
rtl/core/pctd_back.sv
rtl/core/percent_decode_charset_to_utf8.sv
tb/pctd_stream_checker.sv
tb/percent_decode_charset_to_utf8_tb.sv
